>>> rtl/ebam_pkg.sv
// Shared types, constants and codes of the edge-blend alpha mask unit.
`timescale 1ns / 1ps

package ebam_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_CELLS_DEF = 16;
    localparam int COEF_FRAC_DEF = 32;

    // Fixed field widths.
    localparam int COORD_W  = 13;
    localparam int CELLNO_W = 4;
    localparam int SEL_W    = 4;
    localparam int COEF_W   = 48;
    localparam int GRID_W   = 5;
    localparam int CFG_W    = 13;
    localparam int ALPHA_W  = 18;

    // Geometry of the coefficient table.
    localparam int EDGES        = 4;
    localparam int TERMS        = 3;
    localparam int TERMS_CELL   = EDGES * TERMS;

    // Widest cell index: column quotient plus row quotient times grid columns.
    localparam int CELL_W = 18;

    // Curve and ramp arithmetic.
    localparam int DIV_W  = 46;
    localparam int RAMP_W = 17;
    localparam int MAG_W  = 62;
    localparam logic [MAG_W-1:0]  MAG_LIMIT = MAG_W'(1) << 61;
    localparam logic signed [63:0] CURVE_MAX = 64'sd2305843009213693952;
    localparam logic signed [63:0] CURVE_MIN = -64'sd2305843009213693952;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(196608);

    // Edge and term positions inside one cell's row of coefficients.
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_TOP    = 2;
    localparam int EDGE_BOTTOM = 3;
    localparam int TERM_A = 0;
    localparam int TERM_B = 1;
    localparam int TERM_C = 2;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_CELL_WIDTH   = 2'd0,
        CFG_CELL_HEIGHT  = 2'd1,
        CFG_GRID_COLUMNS = 2'd2
    } cfg_reg_t;

    // Request beat.
    typedef struct packed {
        logic                      kind;
        logic [COORD_W-1:0]        pixel_x;
        logic [COORD_W-1:0]        pixel_y;
        logic [CELLNO_W-1:0]       cell_number;
        logic [SEL_W-1:0]          coef_select;
        logic signed [COEF_W-1:0]  coef_value;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               cell_fault;
    } rsp_t;

    // Per-pixel geometry carried past the table read.
    typedef struct packed {
        logic                            fault;
        logic [EDGES-1:0][COORD_W-1:0]   pos;
        logic [EDGES-1:0][COORD_W-1:0]   gap;
    } geom_t;

    // One cell's coefficients, index edge*3+term.
    typedef logic [TERMS_CELL-1:0][COEF_W-1:0] coef_row_t;

    // Flags that travel with the ramp division.
    typedef struct packed {
        logic             fault;
        logic [EDGES-1:0] hit;
    } ramp_tag_t;

endpackage

>>> rtl/ebam_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`timescale 1ns / 1ps

module ebam_div_pipe #(
    parameter int LANES = 2,
    parameter int QW    = 13,
    parameter int DW    = 13,
    parameter int TW    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [TW-1:0]              in_tag,
    input  logic [LANES-1:0][DW-1:0]   in_hi,
    input  logic [LANES-1:0][QW-1:0]   in_lo,
    input  logic [LANES-1:0][DW-1:0]   in_div,
    output logic                       out_valid,
    output logic [TW-1:0]              out_tag,
    output logic [LANES-1:0][QW-1:0]   out_quo,
    output logic [LANES-1:0][DW-1:0]   out_rem
);

    logic                       valid_reg [QW];
    logic [TW-1:0]              tag_reg   [QW];
    logic [LANES-1:0][DW-1:0]   rem_reg   [QW];
    logic [LANES-1:0][DW-1:0]   div_reg   [QW];
    logic [LANES-1:0][QW-1:0]   lo_reg    [QW];
    logic [LANES-1:0][QW-1:0]   quo_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic                       v_cur;
        logic [TW-1:0]              t_cur;
        logic [LANES-1:0][DW-1:0]   rem_cur;
        logic [LANES-1:0][DW-1:0]   div_cur;
        logic [LANES-1:0][QW-1:0]   lo_cur;
        logic [LANES-1:0][QW-1:0]   quo_cur;
        logic [LANES-1:0][DW-1:0]   rem_next;
        logic [LANES-1:0][QW-1:0]   lo_next;
        logic [LANES-1:0][QW-1:0]   quo_next;

        // The first stage takes the beat, later stages the one before.
        if (k == 0) begin : g_first
            assign v_cur   = in_valid;
            assign t_cur   = in_tag;
            assign rem_cur = in_hi;
            assign div_cur = in_div;
            assign lo_cur  = in_lo;
            assign quo_cur = '0;
        end else begin : g_rest
            assign v_cur   = valid_reg[k-1];
            assign t_cur   = tag_reg[k-1];
            assign rem_cur = rem_reg[k-1];
            assign div_cur = div_reg[k-1];
            assign lo_cur  = lo_reg[k-1];
            assign quo_cur = quo_reg[k-1];
        end

        // Shift in the next dividend bit and subtract where it fits.
        always_comb
        begin
            logic [DW:0] trial;
            logic        fits;
            trial = '0;
            fits  = 1'b0;
            for (int l = 0; l < LANES; l++)
            begin
                trial       = {rem_cur[l], lo_cur[l][QW-1]};
                fits        = (trial >= {1'b0, div_cur[l]});
                rem_next[l] = fits ? DW'(trial - {1'b0, div_cur[l]}) : DW'(trial);
                lo_next[l]  = lo_cur[l] << 1;
                quo_next[l] = {quo_cur[l][QW-2:0], fits};
            end
        end

        // Valid bit of the stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_cur;
        end

        // Data of the stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k] <= t_cur;
                rem_reg[k] <= rem_next;
                div_reg[k] <= div_cur;
                lo_reg[k]  <= lo_next;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_rem   = rem_reg[QW-1];

endmodule

>>> rtl/ebam_coef_mem.sv
// Coefficient table: one memory per coefficient, all read for a pixel in one beat.
`timescale 1ns / 1ps

module ebam_coef_mem #(
    parameter int MAX_CELLS = ebam_pkg::MAX_CELLS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic                              in_write,
    input  logic [ebam_pkg::CELLNO_W-1:0]     wr_cell,
    input  logic [ebam_pkg::SEL_W-1:0]        wr_sel,
    input  logic [ebam_pkg::COEF_W-1:0]       wr_value,
    input  logic [((MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1)-1:0] rd_addr,
    input  ebam_pkg::geom_t                   in_geom,
    output logic                              out_valid,
    output ebam_pkg::geom_t                   out_geom,
    output ebam_pkg::coef_row_t               out_coef
);

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    logic          valid_reg;
    ebam_pkg::geom_t geom_reg;
    logic          cell_ok;
    logic [AW-1:0] wr_addr;

    // A write to a cell beyond the table is dropped.
    assign cell_ok = (32'(wr_cell) < MAX_CELLS);
    assign wr_addr = AW'(wr_cell);

    for (genvar t = 0; t < ebam_pkg::TERMS_CELL; t++) begin : g_term
        logic [ebam_pkg::COEF_W-1:0] mem [MAX_CELLS];
        logic [ebam_pkg::COEF_W-1:0] rd_reg;
        logic                        we;

        assign we = en && in_valid && in_write && cell_ok
                    && (wr_sel == ebam_pkg::SEL_W'(t));

        // Write port and registered read port.
        always_ff @(posedge clk)
        begin
            if (we)
                mem[wr_addr] <= wr_value;
            if (en)
                rd_reg <= mem[rd_addr];
        end

        assign out_coef[t] = rd_reg;
    end

    // Only pixel beats carry on past the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid && !in_write;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            geom_reg <= in_geom;
    end

    assign out_valid = valid_reg;
    assign out_geom  = geom_reg;

endmodule

>>> rtl/ebam_curve_pipe.sv
// Quadratic curve per edge, edge test and normalised ramp operands, six stages.
`timescale 1ns / 1ps

module ebam_curve_pipe #(
    parameter int FRAC_BITS = ebam_pkg::COEF_FRAC_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   en,
    input  logic                                                   in_valid,
    input  ebam_pkg::geom_t                                        in_geom,
    input  ebam_pkg::coef_row_t                                    in_coef,
    output logic                                                   out_valid,
    output ebam_pkg::ramp_tag_t                                    out_flags,
    output logic [ebam_pkg::EDGES-1:0][ebam_pkg::DIV_W-1:0]        out_num,
    output logic [ebam_pkg::EDGES-1:0][ebam_pkg::DIV_W-1:0]        out_den
);

    localparam int E = ebam_pkg::EDGES;
    localparam int CW = ebam_pkg::COEF_W;
    localparam int HALF = CW / 2;
    localparam int PW = ebam_pkg::COORD_W;

    logic [5:0] valid_reg;
    logic [5:0] fault_reg;

    // Stage 1: magnitudes, signs, p squared, scaled distance.
    logic [CW-1:0]        amag_reg [E];
    logic [CW-1:0]        bmag_reg [E];
    logic                 asgn1_reg [E];
    logic                 bsgn1_reg [E];
    logic signed [63:0]   tc1_reg  [E];
    logic [PW-1:0]        p_reg    [E];
    logic [2*PW-1:0]      p2_reg   [E];
    logic [63:0]          dd1_reg  [E];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < E; l++)
            begin
                logic [CW-1:0] a;
                logic [CW-1:0] b;
                logic [CW-1:0] c;
                a = in_coef[l*ebam_pkg::TERMS + ebam_pkg::TERM_A];
                b = in_coef[l*ebam_pkg::TERMS + ebam_pkg::TERM_B];
                c = in_coef[l*ebam_pkg::TERMS + ebam_pkg::TERM_C];
                amag_reg[l]  <= a[CW-1] ? (~a + CW'(1)) : a;
                bmag_reg[l]  <= b[CW-1] ? (~b + CW'(1)) : b;
                asgn1_reg[l] <= a[CW-1];
                bsgn1_reg[l] <= b[CW-1];
                tc1_reg[l]   <= $signed({{(64-CW){c[CW-1]}}, c});
                p_reg[l]     <= in_geom.pos[l];
                p2_reg[l]    <= (2*PW)'(in_geom.pos[l]) * (2*PW)'(in_geom.pos[l]);
                dd1_reg[l]   <= 64'(in_geom.gap[l]) << FRAC_BITS;
            end
        end
    end

    // Stage 2: partial products, the a and b coefficients each cut into two halves.
    logic [HALF+2*PW-1:0] ahi_reg [E];
    logic [HALF+2*PW-1:0] alo_reg [E];
    logic [HALF+PW-1:0]   bhi_reg [E];
    logic [HALF+PW-1:0]   blo_reg [E];
    logic                 asgn2_reg [E];
    logic                 bsgn2_reg [E];
    logic signed [63:0]   tc2_reg  [E];
    logic [63:0]          dd2_reg  [E];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < E; l++)
            begin
                ahi_reg[l] <= (HALF+2*PW)'(amag_reg[l][CW-1:HALF]) * (HALF+2*PW)'(p2_reg[l]);
                alo_reg[l] <= (HALF+2*PW)'(amag_reg[l][HALF-1:0]) * (HALF+2*PW)'(p2_reg[l]);
                bhi_reg[l] <= (HALF+PW)'(bmag_reg[l][CW-1:HALF]) * (HALF+PW)'(p_reg[l]);
                blo_reg[l] <= (HALF+PW)'(bmag_reg[l][HALF-1:0]) * (HALF+PW)'(p_reg[l]);
                asgn2_reg[l] <= asgn1_reg[l];
                bsgn2_reg[l] <= bsgn1_reg[l];
                tc2_reg[l]   <= tc1_reg[l];
                dd2_reg[l]   <= dd1_reg[l];
            end
        end
    end

    // Stage 3: join the halves, saturate the magnitude of the a term and restore the signs.
    logic signed [63:0] ta_reg  [E];
    logic signed [63:0] tb_reg  [E];
    logic signed [63:0] tc3_reg [E];
    logic [63:0]        dd3_reg [E];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < E; l++)
            begin
                logic [CW+2*PW-1:0]        aprod;
                logic [ebam_pkg::MAG_W-1:0] asat;
                logic [ebam_pkg::MAG_W-1:0] bprod;
                aprod = ((CW+2*PW)'(ahi_reg[l]) << HALF) + (CW+2*PW)'(alo_reg[l]);
                asat  = (aprod > (CW+2*PW)'(ebam_pkg::MAG_LIMIT)) ? ebam_pkg::MAG_LIMIT
                                                                   : aprod[ebam_pkg::MAG_W-1:0];
                // b times p stays below the limit, as the coefficient has 48 bits.
                bprod = (ebam_pkg::MAG_W'(bhi_reg[l]) << HALF) + ebam_pkg::MAG_W'(blo_reg[l]);
                ta_reg[l]  <= asgn2_reg[l] ? -$signed(64'(asat)) : $signed(64'(asat));
                tb_reg[l]  <= bsgn2_reg[l] ? -$signed(64'(bprod)) : $signed(64'(bprod));
                tc3_reg[l] <= tc2_reg[l];
                dd3_reg[l] <= dd2_reg[l];
            end
        end
    end

    // Stage 4: sum of the three terms, saturated.
    logic signed [63:0] curve_reg [E];
    logic [63:0]        dd4_reg   [E];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < E; l++)
            begin
                logic signed [63:0] sum;
                sum = ta_reg[l] + tb_reg[l] + tc3_reg[l];
                if (sum > ebam_pkg::CURVE_MAX)
                    curve_reg[l] <= ebam_pkg::CURVE_MAX;
                else if (sum < ebam_pkg::CURVE_MIN)
                    curve_reg[l] <= ebam_pkg::CURVE_MIN;
                else
                    curve_reg[l] <= sum;
                dd4_reg[l] <= dd3_reg[l];
            end
        end
    end

    // Stage 5: edge test and the shift that brings the curve below 2^46.
    logic [E-1:0]               hit5_reg;
    logic [ebam_pkg::MAG_W-1:0] cv_reg  [E];
    logic [63:0]                dd5_reg [E];
    logic [4:0]                 sh_reg  [E];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < E; l++)
            begin
                logic [4:0] sh;
                sh = '0;
                for (int i = ebam_pkg::DIV_W; i < ebam_pkg::MAG_W; i++)
                begin
                    if (curve_reg[l][i])
                        sh = 5'(i - ebam_pkg::DIV_W + 1);
                end
                hit5_reg[l] <= (curve_reg[l] > 64'sd0) && (curve_reg[l] > $signed(dd4_reg[l]));
                cv_reg[l]   <= curve_reg[l][ebam_pkg::MAG_W-1:0];
                dd5_reg[l]  <= dd4_reg[l];
                sh_reg[l]   <= sh;
            end
        end
    end

    // Stage 6: numerator and denominator of the ramp.
    logic [E-1:0]                          hit6_reg;
    logic [E-1:0][ebam_pkg::DIV_W-1:0]     num_reg;
    logic [E-1:0][ebam_pkg::DIV_W-1:0]     den_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < E; l++)
            begin
                num_reg[l] <= ebam_pkg::DIV_W'((64'(cv_reg[l]) - dd5_reg[l]) >> sh_reg[l]);
                den_reg[l] <= ebam_pkg::DIV_W'(cv_reg[l] >> sh_reg[l]);
            end
            hit6_reg <= hit5_reg;
        end
    end

    // Valid and fault bits along the six stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fault_reg <= {fault_reg[4:0], in_geom.fault};
    end

    assign out_valid       = valid_reg[5];
    assign out_flags.fault = fault_reg[5];
    assign out_flags.hit   = hit6_reg;
    assign out_num         = num_reg;
    assign out_den         = den_reg;

endmodule

>>> rtl/edge_blend_alpha_mask_unit.sv
// Top level of the edge-blend alpha mask unit.
`timescale 1ns / 1ps

// The unit takes one beat per clock cycle, coefficient writes and pixel
// requests alike. A pixel passes 39 register stages: cell division (one
// quotient bit per stage), forming the cell index, the table read, curve
// evaluation, ramp division and the output register. Writes pass down the
// same pipeline and reach the table in order with the pixels. The whole
// pipeline holds while a result waits under stall; otherwise a new beat is
// taken every cycle. The coefficient table is undefined until written and
// needs no clearing after reset. A pixel whose cell lies beyond the table
// returns alpha zero with cell_fault set.
module edge_blend_alpha_mask_unit #(
    parameter int MAX_CELLS      = ebam_pkg::MAX_CELLS_DEF,
    parameter int COEF_FRAC_BITS = ebam_pkg::COEF_FRAC_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  ebam_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output ebam_pkg::rsp_t               rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [ebam_pkg::CFG_W-1:0]   cfg_data
);

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int PW = ebam_pkg::COORD_W;
    localparam int RW = $bits(ebam_pkg::req_t);

    logic [PW-1:0]                cell_width_reg;
    logic [PW-1:0]                cell_height_reg;
    logic [ebam_pkg::GRID_W-1:0]  grid_columns_reg;
    logic [PW-1:0]                cw_eff;
    logic [PW-1:0]                ch_eff;
    logic                         adv;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg   <= PW'(1024);
            cell_height_reg  <= PW'(768);
            grid_columns_reg <= ebam_pkg::GRID_W'(1);
        end
        else if (cfg_valid)
        begin
            case (ebam_pkg::cfg_reg_t'(cfg_index))
                ebam_pkg::CFG_CELL_WIDTH:   cell_width_reg   <= cfg_data;
                ebam_pkg::CFG_CELL_HEIGHT:  cell_height_reg  <= cfg_data;
                ebam_pkg::CFG_GRID_COLUMNS: grid_columns_reg <= cfg_data[ebam_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // A cell size of zero acts as one.
    assign cw_eff = (cell_width_reg == '0) ? PW'(1) : cell_width_reg;
    assign ch_eff = (cell_height_reg == '0) ? PW'(1) : cell_height_reg;

    // The pipeline moves unless a finished result is held back.
    assign adv       = !rsp_valid || !rsp_stall;
    assign req_stall = !adv;

    // Cell division: lane 0 splits x by the cell width, lane 1 y by the height.
    logic                      cd_valid;
    logic [RW-1:0]             cd_tag;
    logic [1:0][PW-1:0]        cd_quo;
    logic [1:0][PW-1:0]        cd_rem;
    ebam_pkg::req_t            cd_req;

    ebam_div_pipe #(
        .LANES (2),
        .QW    (PW),
        .DW    (PW),
        .TW    (RW)
    ) u_cell_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (req_valid),
        .in_tag    (req),
        .in_hi     ('0),
        .in_lo     ({req.pixel_y, req.pixel_x}),
        .in_div    ({ch_eff, cw_eff}),
        .out_valid (cd_valid),
        .out_tag   (cd_tag),
        .out_quo   (cd_quo),
        .out_rem   (cd_rem)
    );

    assign cd_req = ebam_pkg::req_t'(cd_tag);

    // Cell index, fault and the distances to the left, right, top and bottom edges.
    logic                            ci_valid_reg;
    logic                            ci_write_reg;
    logic [ebam_pkg::CELLNO_W-1:0]   ci_cell_reg;
    logic [ebam_pkg::SEL_W-1:0]      ci_sel_reg;
    logic [ebam_pkg::COEF_W-1:0]     ci_value_reg;
    logic [AW-1:0]                   ci_addr_reg;
    ebam_pkg::geom_t                 ci_geom_reg;
    logic [ebam_pkg::CELL_W-1:0]     cell_idx;

    assign cell_idx = ebam_pkg::CELL_W'(cd_quo[0])
                    + ebam_pkg::CELL_W'(cd_quo[1]) * ebam_pkg::CELL_W'(grid_columns_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ci_valid_reg <= 1'b0;
        else if (adv)
            ci_valid_reg <= cd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ci_write_reg <= (cd_req.kind == ebam_pkg::KIND_WRITE);
            ci_cell_reg  <= cd_req.cell_number;
            ci_sel_reg   <= cd_req.coef_select;
            ci_value_reg <= cd_req.coef_value;
            ci_addr_reg  <= cell_idx[AW-1:0];
            ci_geom_reg.fault                      <= (32'(cell_idx) >= MAX_CELLS);
            ci_geom_reg.pos[ebam_pkg::EDGE_LEFT]   <= cd_rem[1];
            ci_geom_reg.pos[ebam_pkg::EDGE_RIGHT]  <= cd_rem[1];
            ci_geom_reg.pos[ebam_pkg::EDGE_TOP]    <= cd_rem[0];
            ci_geom_reg.pos[ebam_pkg::EDGE_BOTTOM] <= cd_rem[0];
            ci_geom_reg.gap[ebam_pkg::EDGE_LEFT]   <= cd_rem[0];
            ci_geom_reg.gap[ebam_pkg::EDGE_RIGHT]  <= cw_eff - cd_rem[0];
            ci_geom_reg.gap[ebam_pkg::EDGE_TOP]    <= cd_rem[1];
            ci_geom_reg.gap[ebam_pkg::EDGE_BOTTOM] <= ch_eff - cd_rem[1];
        end
    end

    // Table write or read.
    logic                 tm_valid;
    ebam_pkg::geom_t      tm_geom;
    ebam_pkg::coef_row_t  tm_coef;

    ebam_coef_mem #(
        .MAX_CELLS (MAX_CELLS)
    ) u_coef_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (ci_valid_reg),
        .in_write  (ci_write_reg),
        .wr_cell   (ci_cell_reg),
        .wr_sel    (ci_sel_reg),
        .wr_value  (ci_value_reg),
        .rd_addr   (ci_addr_reg),
        .in_geom   (ci_geom_reg),
        .out_valid (tm_valid),
        .out_geom  (tm_geom),
        .out_coef  (tm_coef)
    );

    // Curves and ramp operands.
    logic                                                  cv_valid;
    ebam_pkg::ramp_tag_t                                   cv_flags;
    logic [ebam_pkg::EDGES-1:0][ebam_pkg::DIV_W-1:0]       cv_num;
    logic [ebam_pkg::EDGES-1:0][ebam_pkg::DIV_W-1:0]       cv_den;

    ebam_curve_pipe #(
        .FRAC_BITS (COEF_FRAC_BITS)
    ) u_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (tm_valid),
        .in_geom   (tm_geom),
        .in_coef   (tm_coef),
        .out_valid (cv_valid),
        .out_flags (cv_flags),
        .out_num   (cv_num),
        .out_den   (cv_den)
    );

    // Ramp division: numerator times 2^16 over the denominator, one lane per edge.
    logic [ebam_pkg::EDGES-1:0][ebam_pkg::DIV_W-1:0]   rd_hi;
    logic [ebam_pkg::EDGES-1:0][ebam_pkg::RAMP_W-1:0]  rd_lo;
    logic                                              rd_valid;
    logic [$bits(ebam_pkg::ramp_tag_t)-1:0]            rd_tag;
    ebam_pkg::ramp_tag_t                               rd_flags;
    logic [ebam_pkg::EDGES-1:0][ebam_pkg::RAMP_W-1:0]  rd_quo;
    logic [ebam_pkg::EDGES-1:0][ebam_pkg::DIV_W-1:0]   rd_rem;

    always_comb
    begin
        for (int l = 0; l < ebam_pkg::EDGES; l++)
        begin
            rd_hi[l] = {1'b0, cv_num[l][ebam_pkg::DIV_W-1:1]};
            rd_lo[l] = {cv_num[l][0], (ebam_pkg::RAMP_W-1)'(0)};
        end
    end

    ebam_div_pipe #(
        .LANES (ebam_pkg::EDGES),
        .QW    (ebam_pkg::RAMP_W),
        .DW    (ebam_pkg::DIV_W),
        .TW    ($bits(ebam_pkg::ramp_tag_t))
    ) u_ramp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (cv_valid),
        .in_tag    (cv_flags),
        .in_hi     (rd_hi),
        .in_lo     (rd_lo),
        .in_div    (cv_den),
        .out_valid (rd_valid),
        .out_tag   (rd_tag),
        .out_quo   (rd_quo),
        .out_rem   (rd_rem)
    );

    assign rd_flags = ebam_pkg::ramp_tag_t'(rd_tag);

    // Right ramp replaces left, top and bottom ramps are added.
    logic [ebam_pkg::ALPHA_W-1:0] side;
    logic [ebam_pkg::ALPHA_W-1:0] alpha_sum;
    logic                         rem_unused;

    always_comb
    begin
        side = '0;
        if (rd_flags.hit[ebam_pkg::EDGE_RIGHT])
            side = ebam_pkg::ALPHA_W'(rd_quo[ebam_pkg::EDGE_RIGHT]);
        else if (rd_flags.hit[ebam_pkg::EDGE_LEFT])
            side = ebam_pkg::ALPHA_W'(rd_quo[ebam_pkg::EDGE_LEFT]);
        alpha_sum = side;
        if (rd_flags.hit[ebam_pkg::EDGE_TOP])
            alpha_sum = alpha_sum + ebam_pkg::ALPHA_W'(rd_quo[ebam_pkg::EDGE_TOP]);
        if (rd_flags.hit[ebam_pkg::EDGE_BOTTOM])
            alpha_sum = alpha_sum + ebam_pkg::ALPHA_W'(rd_quo[ebam_pkg::EDGE_BOTTOM]);
    end

    // The division remainder has no use for the ramp.
    assign rem_unused = ^rd_rem;

    // Output register.
    logic           rsp_valid_reg;
    ebam_pkg::rsp_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= rd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg.alpha      <= rd_flags.fault ? '0 : alpha_sum;
            rsp_reg.cell_fault <= rd_flags.fault || (rem_unused && 1'b0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/ebam_checker.sv
// Port-level checks of the edge-blend alpha mask unit and their binding.
`timescale 1ns / 1ps

module ebam_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_stall,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input ebam_pkg::rsp_t  rsp
);

    // A faulty pixel never carries a ramp.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.cell_fault |-> rsp.alpha == '0)
        else $error("fault beat with non-zero alpha");

    // The sum of the ramps stays within three.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.alpha <= ebam_pkg::ALPHA_MAX)
        else $error("alpha above its range");

    // Requests are held back only while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rsp_valid && rsp_stall) |-> !req_stall)
        else $error("request stalled with no result waiting");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result beat changed");

endmodule

bind edge_blend_alpha_mask_unit ebam_checker u_ebam_checker (.*);

>>> test/edge_blend_alpha_mask_unit_tb.sv
// Self-checking testbench for the edge-blend alpha mask unit.
`timescale 1ns / 1ps

module edge_blend_alpha_mask_unit_tb;

    localparam int CELLS      = 16;
    localparam int FRAC       = 32;
    localparam int PIPE_DEPTH = 45;
    localparam int CYCLE_CAP  = 600000;
    localparam logic [127:0] SAT_LIM = 128'd1 << 61;
    localparam logic [63:0]  DIV_CAP = 64'd1 << 46;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    ebam_pkg::req_t   req;
    logic             rsp_valid;
    logic             rsp_stall;
    ebam_pkg::rsp_t   rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [ebam_pkg::CFG_W-1:0] cfg_data;

    // Shadow of the block's state.
    logic signed [ebam_pkg::COEF_W-1:0] coef_shadow [CELLS*ebam_pkg::TERMS_CELL];
    logic [12:0] cur_width;
    logic [12:0] cur_height;
    logic [4:0]  cur_columns;

    ebam_pkg::rsp_t alpha_queue [$];
    int   errors;
    int   cycles;
    bit   calm;
    int   hold_request;
    int   hold_left;

    edge_blend_alpha_mask_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL edge_blend_alpha_mask_unit");
            $finish;
        end
    end

    // One curve term: magnitude times factor, saturated, sign kept.
    function automatic logic signed [63:0] scaled_term(logic signed [ebam_pkg::COEF_W-1:0] v,
                                                       logic [31:0] m);
        logic [127:0] mag;
        logic [127:0] prod;
        mag  = v < 0 ? 128'(-64'(v)) : 128'(64'(v));
        prod = mag * 128'(m);
        if (prod > SAT_LIM)
            prod = SAT_LIM;
        return v < 0 ? -$signed(64'(prod)) : $signed(64'(prod));
    endfunction

    // Ramp of one edge in Q.16; hit tells whether the distance lies under the curve.
    function automatic logic [31:0] edge_ramp_of(int base, logic [31:0] p,
                                                 logic [31:0] gap, output bit hit);
        logic signed [63:0] curve;
        logic [63:0] dd;
        logic [63:0] cv;
        int sh;
        curve = scaled_term(coef_shadow[base], p * p)
              + scaled_term(coef_shadow[base + 1], p)
              + scaled_term(coef_shadow[base + 2], 32'd1);
        if (curve > ebam_pkg::CURVE_MAX)
            curve = ebam_pkg::CURVE_MAX;
        if (curve < ebam_pkg::CURVE_MIN)
            curve = ebam_pkg::CURVE_MIN;
        dd  = 64'(gap) << FRAC;
        hit = 1'b0;
        if (curve <= 0 || 64'(curve) <= dd)
            return 0;
        hit = 1'b1;
        cv  = 64'(curve);
        sh  = 0;
        while ((cv >> sh) >= DIV_CAP)
            sh++;
        return 32'(((((cv - dd) >> sh)) << 16) / (cv >> sh));
    endfunction

    // Expected alpha beat for one pixel request.
    function automatic ebam_pkg::rsp_t alpha_for(ebam_pkg::req_t r);
        logic [31:0] cw, ch, px, py, cell_no, alpha, ramp;
        bit hit;
        ebam_pkg::rsp_t o;
        int base;
        cw      = cur_width == 0 ? 32'd1 : 32'(cur_width);
        ch      = cur_height == 0 ? 32'd1 : 32'(cur_height);
        px      = 32'(r.pixel_x) % cw;
        py      = 32'(r.pixel_y) % ch;
        cell_no = 32'(r.pixel_x) / cw + (32'(r.pixel_y) / ch) * 32'(cur_columns);
        o.alpha      = '0;
        o.cell_fault = 1'b1;
        if (cell_no >= CELLS)
            return o;
        base  = int'(cell_no) * ebam_pkg::TERMS_CELL;
        alpha = 0;
        ramp  = edge_ramp_of(base + ebam_pkg::EDGE_LEFT * ebam_pkg::TERMS, py, px, hit);
        if (hit)
            alpha = ramp;
        ramp = edge_ramp_of(base + ebam_pkg::EDGE_RIGHT * ebam_pkg::TERMS, py, cw - px, hit);
        if (hit)
            alpha = ramp;
        alpha += edge_ramp_of(base + ebam_pkg::EDGE_TOP * ebam_pkg::TERMS, px, py, hit);
        alpha += edge_ramp_of(base + ebam_pkg::EDGE_BOTTOM * ebam_pkg::TERMS, px, ch - py,
                              hit);
        o.alpha      = alpha[ebam_pkg::ALPHA_W-1:0];
        o.cell_fault = 1'b0;
        return o;
    endfunction

    // Mismatch reporting.
    task automatic report(string what, longint want, longint got);
        $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
        errors++;
    endtask

    // Result checking against the oldest expected alpha.
    always @(posedge clk)
    begin
        ebam_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (alpha_queue.size() == 0)
            begin
                report("unexpected beat", 0, 1);
            end
            else
            begin
                want = alpha_queue.pop_front();
                if (rsp.alpha !== want.alpha)
                    report("alpha", want.alpha, rsp.alpha);
                if (rsp.cell_fault !== want.cell_fault)
                    report("cell_fault", want.cell_fault, rsp.cell_fault);
            end
        end
    end

    // Receiver: random stalls, quiet stretches and long hold-offs.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
        end
    end

    // Random 83-bit beat with every field filled.
    function automatic ebam_pkg::req_t noise_beat();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(ebam_pkg::req_t)-1:0];
    endfunction

    // Coefficient with a shape that gives edge ramps, sometimes arbitrary.
    function automatic logic signed [ebam_pkg::COEF_W-1:0] shaped_coef(int term);
        logic signed [63:0] v;
        ebam_pkg::req_t nb;
        if ($urandom_range(0, 9) == 0)
        begin
            nb = noise_beat();
            return nb.coef_value;
        end
        case (term)
            ebam_pkg::TERM_A:
                v = 64'(signed'(32'($urandom_range(0, 1 << 19)))) - (64'sd1 << 18);
            ebam_pkg::TERM_B:
                v = 64'(signed'(32'($urandom_range(0, 1 << 27)))) - (64'sd1 << 26);
            default:
                v = 64'($urandom_range(0, 300)) << FRAC;
        endcase
        if (term == ebam_pkg::TERM_C && $urandom_range(0, 9) == 0)
            v = -v;
        return v[ebam_pkg::COEF_W-1:0];
    endfunction

    function automatic ebam_pkg::req_t write_beat(int cell_no, int sel,
                                                  logic signed [ebam_pkg::COEF_W-1:0] val);
        ebam_pkg::req_t r;
        r             = noise_beat();
        r.kind        = ebam_pkg::KIND_WRITE;
        r.cell_number = cell_no[ebam_pkg::CELLNO_W-1:0];
        r.coef_select = sel[ebam_pkg::SEL_W-1:0];
        r.coef_value  = val;
        return r;
    endfunction

    function automatic ebam_pkg::req_t pixel_beat(int x, int y);
        ebam_pkg::req_t r;
        r         = noise_beat();
        r.kind    = ebam_pkg::KIND_PIXEL;
        r.pixel_x = x[ebam_pkg::COORD_W-1:0];
        r.pixel_y = y[ebam_pkg::COORD_W-1:0];
        return r;
    endfunction

    // Pixel mostly inside the first cells of the grid, now and then anywhere.
    function automatic ebam_pkg::req_t random_pixel();
        int xs, ys;
        if ($urandom_range(0, 9) == 0)
            return pixel_beat($urandom_range(0, 8191), $urandom_range(0, 8191));
        xs = (cur_width == 0 ? 1 : int'(cur_width)) * 4;
        ys = (cur_height == 0 ? 1 : int'(cur_height)) * 4;
        return pixel_beat($urandom_range(0, xs > 8191 ? 8191 : xs - 1),
                          $urandom_range(0, ys > 8191 ? 8191 : ys - 1));
    endfunction

    // Sends one beat and updates the shadow state when it is taken.
    task automatic send_beat(ebam_pkg::req_t r);
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (r.kind == ebam_pkg::KIND_PIXEL)
            alpha_queue.push_back(alpha_for(r));
        else if (r.coef_select < ebam_pkg::TERMS_CELL)
            coef_shadow[int'(r.cell_number) * ebam_pkg::TERMS_CELL + int'(r.coef_select)]
                = r.coef_value;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (alpha_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    // Register write, issued only while the unit is idle; the caller drops valid.
    task automatic write_reg(ebam_pkg::cfg_reg_t idx, logic [ebam_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ebam_pkg::CFG_CELL_WIDTH:  cur_width   = val;
            ebam_pkg::CFG_CELL_HEIGHT: cur_height  = val;
            default:                   cur_columns = val[4:0];
        endcase
    endtask

    task automatic set_geometry(int w, int h, int cols);
        drain();
        write_reg(ebam_pkg::CFG_CELL_WIDTH, ebam_pkg::CFG_W'(w));
        write_reg(ebam_pkg::CFG_CELL_HEIGHT, ebam_pkg::CFG_W'(h));
        write_reg(ebam_pkg::CFG_GRID_COLUMNS, ebam_pkg::CFG_W'(cols));
        cfg_valid <= 1'b0;
    endtask

    // Random pixels mixed with a few coefficient rewrites.
    task automatic mixed_traffic(int count);
        int sel;
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                sel = $urandom_range(0, 15);
                send_beat(write_beat($urandom_range(0, 15), sel,
                                     shaped_coef(sel % ebam_pkg::TERMS)));
            end
            else
            begin
                send_beat(random_pixel());
            end
        end
    endtask

    // Every table entry gets a value before any pixel reads it.
    task automatic test_table_load();
        for (int c = 0; c < CELLS; c++)
            for (int s = 0; s < ebam_pkg::TERMS_CELL; s++)
                send_beat(write_beat(c, s, shaped_coef(s % ebam_pkg::TERMS)));
    endtask

    // Field extremes, ignored writes, full ramp and out-of-table cells.
    task automatic test_directed();
        send_beat(pixel_beat(0, 0));
        send_beat(pixel_beat(8191, 8191));
        send_beat(pixel_beat(1023, 767));
        send_beat(pixel_beat(1024, 0));
        send_beat(pixel_beat(0, 768 * 15));
        send_beat(write_beat(0, 12, 48'sh7FFF_FFFF_FFFF));
        send_beat(write_beat(1, 15, 48'sh8000_0000_0000));
        send_beat(pixel_beat(5, 9));
        send_beat(write_beat(0, ebam_pkg::EDGE_LEFT * ebam_pkg::TERMS + ebam_pkg::TERM_C,
                             48'sh7FFF_FFFF_FFFF));
        send_beat(write_beat(0, ebam_pkg::EDGE_LEFT * ebam_pkg::TERMS + ebam_pkg::TERM_A,
                             48'sh7FFF_FFFF_FFFF));
        send_beat(write_beat(0, ebam_pkg::EDGE_TOP * ebam_pkg::TERMS + ebam_pkg::TERM_A,
                             48'sh8000_0000_0000));
        send_beat(write_beat(0, ebam_pkg::EDGE_TOP * ebam_pkg::TERMS + ebam_pkg::TERM_B,
                             48'sh8000_0000_0000));
        send_beat(pixel_beat(0, 0));
        send_beat(pixel_beat(0, 500));
        send_beat(pixel_beat(1023, 0));
        send_beat(pixel_beat(700, 3));
        send_beat(write_beat(15, ebam_pkg::EDGE_RIGHT * ebam_pkg::TERMS + ebam_pkg::TERM_C,
                             ebam_pkg::COEF_W'(64'(200) << FRAC)));
        send_beat(write_beat(15, ebam_pkg::EDGE_BOTTOM * ebam_pkg::TERMS + ebam_pkg::TERM_C,
                             48'sh0000_0000_0001));
        send_beat(pixel_beat(1024 * 7 + 1023, 0));
        send_beat(pixel_beat(1024 * 7 + 1000, 0));
    endtask

    // Geometry extremes, zero sizes and columns spilling into the next row.
    task automatic test_geometry_sweep();
        set_geometry(1, 1, 16);
        mixed_traffic(60);
        set_geometry(8191, 8191, 16);
        mixed_traffic(60);
        set_geometry(0, 0, 0);
        mixed_traffic(50);
        set_geometry(100, 80, 31);
        mixed_traffic(60);
        set_geometry(64, 48, 4);
        mixed_traffic(120);
    endtask

    // Long receiver hold-off while the sender keeps offering beats.
    task automatic test_backpressure();
        hold_request = 300;
        mixed_traffic(150);
    endtask

    // Back-to-back traffic with no idling at all.
    task automatic test_full_rate();
        calm = 1'b1;
        mixed_traffic(250);
        calm = 1'b0;
    endtask

    // Random geometries with random traffic in between.
    task automatic test_random();
        repeat (6)
        begin
            set_geometry($urandom_range(8, 300), $urandom_range(8, 300),
                         $urandom_range(1, 6));
            mixed_traffic(90);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = ebam_pkg::CFG_CELL_WIDTH;
        cfg_data     = '0;
        errors       = 0;
        cycles       = 0;
        calm         = 1'b0;
        hold_request = 0;
        hold_left    = 0;
        cur_width    = 13'd1024;
        cur_height   = 13'd768;
        cur_columns  = 5'd1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_directed();
        mixed_traffic(80);
        test_geometry_sweep();
        test_backpressure();
        test_full_rate();
        test_random();
        drain();

        if (errors == 0)
            $display("PASS edge_blend_alpha_mask_unit");
        else
            $display("FAIL edge_blend_alpha_mask_unit");
        $finish;
    end

endmodule
